/* rtl/htnm_pkg.sv */
// Shared types and constants for the height to normal map block.
package htnm_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int CntW      = 11;
    localparam logic [15:0] UnitZ = 16'd65280;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegGain   = 2'd2;

    localparam logic OpPixel = 1'b0;
    localparam logic OpFlush = 1'b1;

    // one window job handed from the front end to the shading unit
    typedef struct packed {
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic               frame_end;
    } job_t;

    typedef enum logic [2:0] {
        SH_IDLE,
        SH_MULT,
        SH_SQUARE,
        SH_ROOT,
        SH_DIVIDE,
        SH_DONE
    } sh_state_t;

endpackage

/* rtl/htnm_front.sv */
// Front end: row stores, 3x3 window, counters and Sobel gradients.
module htnm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_take,
    input  logic                 opcode,
    input  logic [7:0]           height_sample,
    input  logic                 restart,
    input  logic [10:0]          image_width,
    input  logic [10:0]          image_height,
    output logic                 job_valid,
    output htnm_pkg::job_t       job
);

    logic [7:0] upper_mem [htnm_pkg::MaxWidth];
    logic [7:0] middle_mem [htnm_pkg::MaxWidth];

    logic [7:0] win_reg [9];
    logic [7:0] win_next [9];
    logic [htnm_pkg::CntW-1:0] col_reg, col_next;
    logic [htnm_pkg::CntW-1:0] row_reg, row_next;
    logic [htnm_pkg::CntW-1:0] pend_reg, pend_next;
    logic [htnm_pkg::CntW-1:0] w_eff, h_eff;
    logic [htnm_pkg::ColW-1:0] col_idx, rd_idx;
    logic [7:0] up_rd_reg, mid_rd_reg, top, mid, bot;
    logic draining, active, valid_now, wr_en, end_drain;
    logic [htnm_pkg::CntW-1:0] vrow;
    logic [7:0] l0, l1, l2, m0, m2, r0, r1, r2;
    logic signed [11:0] gx, gy;

    always_comb
    begin
        w_eff = (image_width == '0) ? 11'd1 :
                (image_width > 11'(htnm_pkg::MaxWidth)) ? 11'(htnm_pkg::MaxWidth) : image_width;
        h_eff = (image_height == '0) ? 11'd1 :
                (image_height > 11'(htnm_pkg::MaxHeight)) ? 11'(htnm_pkg::MaxHeight) : image_height;
    end

    assign col_idx  = col_reg[htnm_pkg::ColW-1:0];
    assign draining = (pend_reg != '0);
    // a flush while pixels are expected is dropped
    assign active   = in_take && (draining || opcode == htnm_pkg::OpPixel);
    assign wr_en    = active && !draining;
    assign end_drain = active && draining && (pend_next == '0);

    // address of the column the next word will use
    always_comb
    begin
        if (restart || end_drain)
        begin
            rd_idx = '0;
        end
        else if (active)
        begin
            rd_idx = col_next[htnm_pkg::ColW-1:0];
        end
        else
        begin
            rd_idx = col_idx;
        end
    end

    always_comb
    begin
        if (!draining)
        begin
            vrow = row_reg;
            mid  = (row_reg >= 11'd1) ? mid_rd_reg : height_sample;
            top  = (row_reg >= 11'd2) ? up_rd_reg : mid;
            bot  = height_sample;
        end
        else
        begin
            vrow = h_eff + ((pend_reg == 11'd1) ? 11'd1 : 11'd0);
            mid  = mid_rd_reg;
            top  = (vrow >= 11'd2) ? up_rd_reg : mid;
            bot  = mid;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            win_next[k] = win_reg[k];
        end
        if (col_reg == '0)
        begin
            // right edge of the previous row: replicate the right column
            l0 = win_reg[3]; l1 = win_reg[4]; l2 = win_reg[5];
            m0 = win_reg[6]; m2 = win_reg[8];
            r0 = win_reg[6]; r1 = win_reg[7]; r2 = win_reg[8];
            win_next[0] = top; win_next[3] = top; win_next[6] = top;
            win_next[1] = mid; win_next[4] = mid; win_next[7] = mid;
            win_next[2] = bot; win_next[5] = bot; win_next[8] = bot;
        end
        else
        begin
            l0 = win_reg[3]; l1 = win_reg[4]; l2 = win_reg[5];
            m0 = win_reg[6]; m2 = win_reg[8];
            r0 = top; r1 = mid; r2 = bot;
            for (int k = 0; k < 6; k++)
            begin
                win_next[k] = win_reg[k+3];
            end
            win_next[6] = top; win_next[7] = mid; win_next[8] = bot;
        end
        gx = (12'(r0) - 12'(l0)) + 12'(signed'({1'b0, r1, 1'b0}) - signed'({1'b0, l1, 1'b0}))
             + (12'(r2) - 12'(l2));
        gy = (12'(l2) - 12'(l0)) + 12'(signed'({1'b0, m2, 1'b0}) - signed'({1'b0, m0, 1'b0}))
             + (12'(r2) - 12'(r0));
    end

    assign valid_now = (vrow >= 11'd2) || (vrow == 11'd1 && col_reg >= 11'd1);

    always_comb
    begin
        col_next  = (col_reg + 11'd1 >= w_eff) ? '0 : col_reg + 11'd1;
        row_next  = row_reg;
        pend_next = pend_reg;
        if (!draining)
        begin
            if (col_next == '0)
            begin
                row_next = row_reg + 11'd1;
                if (row_reg + 11'd1 >= h_eff)
                begin
                    row_next  = h_eff;
                    pend_next = w_eff + 11'd1;
                end
            end
        end
        else
        begin
            pend_next = pend_reg - 11'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[col_idx]  <= mid_rd_reg;
            middle_mem[col_idx] <= height_sample;
        end
        // fetch the next column ahead; forward a word written to that same column
        if (wr_en && rd_idx == col_idx)
        begin
            up_rd_reg  <= mid_rd_reg;
            mid_rd_reg <= height_sample;
        end
        else
        begin
            up_rd_reg  <= upper_mem[rd_idx];
            mid_rd_reg <= middle_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            job_valid <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (restart)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            job_valid <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            job_valid <= active && valid_now;
            if (active)
            begin
                // end of drain restarts the frame
                if (draining && pend_next == '0)
                begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    pend_reg <= '0;
                    for (int k = 0; k < 9; k++)
                    begin
                        win_reg[k] <= '0;
                    end
                end
                else
                begin
                    col_reg  <= col_next;
                    row_reg  <= row_next;
                    pend_reg <= pend_next;
                    for (int k = 0; k < 9; k++)
                    begin
                        win_reg[k] <= win_next[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            job.gx        <= gx;
            job.gy        <= gy;
            job.frame_end <= draining && pend_reg == 11'd1;
        end
    end

    ap_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < 11'(htnm_pkg::MaxWidth))
        else $error("column counter out of range");
    ap_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 11'(htnm_pkg::MaxWidth) + 11'd1)
        else $error("drain count too large");
    ap_drop_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && !draining && opcode == htnm_pkg::OpFlush && !restart) |=> !job_valid)
        else $error("flush before frame end produced a result");

endmodule

/* rtl/htnm_queue.sv */
// Short job queue between the front end and the shading unit.
module htnm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  htnm_pkg::job_t push_job,
    input  logic           pop,
    output logic           not_empty,
    output logic           almost_full,
    output htnm_pkg::job_t head
);

    htnm_pkg::job_t mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;

    assign not_empty   = (cnt_reg != '0);
    // two slots kept for words already in the front pipeline
    assign almost_full = (cnt_reg >= 3'd2);
    assign head        = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

    ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> cnt_reg < 3'd4)
        else $error("job queue overflow");
    ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("job queue underflow");
    ap_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("queue count did not advance");

endmodule

/* rtl/htnm_shade.sv */
// Shading unit: gain scaling, squared length, bitwise root and byte mapping.
module htnm_shade (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [15:0]    gain,
    input  logic           job_valid,
    input  htnm_pkg::job_t job,
    output logic           job_take,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     normal_red,
    output logic [7:0]     normal_green,
    output logic [7:0]     normal_blue,
    output logic           frame_end
);

    htnm_pkg::sh_state_t state_reg, state_next;

    logic [10:0] agx_reg, agy_reg;
    logic        sx_reg, sy_reg, fe_reg;
    logic [26:0] ua_reg, ub_reg;
    logic [55:0] s_reg;
    logic [63:0] v_reg, r_reg, bit_reg;
    logic [4:0]  step_reg;
    logic [1:0]  comp_reg;
    logic [31:0] len;
    logic [33:0] den_reg;
    logic [38:0] rem_reg;
    logic [8:0]  lo_reg;
    logic [8:0]  q_reg;
    logic [3:0]  qstep_reg;
    logic [7:0]  byte_reg [3];
    logic        mult_phase_reg;
    logic [63:0] trial;
    logic [38:0] num;
    logic signed [33:0] cval;
    logic [38:0] shifted;
    logic [7:0]  byte_sat;

    assign len   = r_reg[31:0];
    assign trial = r_reg + bit_reg;

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    cval = sx_reg ? 34'(ua_reg) : -34'(ua_reg);
            2'd1:    cval = sy_reg ? 34'(ub_reg) : -34'(ub_reg);
            default: cval = 34'(htnm_pkg::UnitZ);
        endcase
        // numerator of floor((510*(L+c) + 2L) / (4L)), at most 9 bits of quotient
        num = 39'(510) * 39'(signed'(34'(len)) + cval) + 39'({len, 1'b0});
        shifted = {rem_reg[37:0], lo_reg[8]};
        byte_sat = q_reg[8] ? 8'hFF : q_reg[7:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            htnm_pkg::SH_IDLE:   if (job_valid) state_next = htnm_pkg::SH_MULT;
            htnm_pkg::SH_MULT:   if (mult_phase_reg) state_next = htnm_pkg::SH_SQUARE;
            htnm_pkg::SH_SQUARE: state_next = htnm_pkg::SH_ROOT;
            htnm_pkg::SH_ROOT:   if (step_reg == 5'd31) state_next = htnm_pkg::SH_DIVIDE;
            htnm_pkg::SH_DIVIDE:
                if (comp_reg == 2'd2 && qstep_reg == 4'd10) state_next = htnm_pkg::SH_DONE;
            htnm_pkg::SH_DONE:   if (out_ready) state_next = htnm_pkg::SH_IDLE;
            default:             state_next = htnm_pkg::SH_IDLE;
        endcase
    end

    always_comb
    begin
        job_take  = (state_reg == htnm_pkg::SH_IDLE) && job_valid;
        out_valid = (state_reg == htnm_pkg::SH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htnm_pkg::SH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            htnm_pkg::SH_IDLE:
            begin
                // a = -gain*gx: sign of a is opposite to gx
                agx_reg <= job.gx[11] ? 11'(-job.gx) : job.gx[10:0];
                agy_reg <= job.gy[11] ? 11'(-job.gy) : job.gy[10:0];
                sx_reg  <= job.gx[11];
                sy_reg  <= job.gy[11];
                fe_reg  <= job.frame_end;
                mult_phase_reg <= 1'b0;
            end
            htnm_pkg::SH_MULT:
            begin
                if (!mult_phase_reg)
                begin
                    ua_reg <= 27'(gain) * 27'(agx_reg);
                    ub_reg <= 27'(gain) * 27'(agy_reg);
                    mult_phase_reg <= 1'b1;
                end
                else
                begin
                    s_reg <= 56'(ua_reg) * 56'(ua_reg);
                end
            end
            htnm_pkg::SH_SQUARE:
            begin
                v_reg    <= 64'(s_reg) + 64'(56'(ub_reg) * 56'(ub_reg))
                            + 64'(htnm_pkg::UnitZ) * 64'(htnm_pkg::UnitZ);
                r_reg    <= '0;
                bit_reg  <= 64'd1 << 62;
                step_reg <= '0;
            end
            htnm_pkg::SH_ROOT:
            begin
                if (v_reg >= trial)
                begin
                    v_reg <= v_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg + 5'd1;
                comp_reg  <= '0;
                qstep_reg <= '0;
            end
            htnm_pkg::SH_DIVIDE:
            begin
                // restoring division, one quotient bit a cycle, 9 bits per component
                if (qstep_reg == '0)
                begin
                    // seed remainder with numerator high part
                    den_reg   <= {len, 2'b00};
                    rem_reg   <= 39'(num >> 9);
                    lo_reg    <= num[8:0];
                    q_reg     <= '0;
                    qstep_reg <= 4'd1;
                end
                else if (qstep_reg <= 4'd9)
                begin
                    if (shifted >= 39'(den_reg))
                    begin
                        rem_reg <= shifted - 39'(den_reg);
                        q_reg   <= {q_reg[7:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= shifted;
                        q_reg   <= {q_reg[7:0], 1'b0};
                    end
                    lo_reg    <= {lo_reg[7:0], 1'b0};
                    qstep_reg <= qstep_reg + 4'd1;
                end
                else
                begin
                    byte_reg[comp_reg] <= byte_sat;
                    comp_reg  <= comp_reg + 2'd1;
                    qstep_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign normal_red   = byte_reg[0];
    assign normal_green = byte_reg[1];
    assign normal_blue  = byte_reg[2];
    assign frame_end    = fe_reg;

    ap_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    ap_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> state_reg == htnm_pkg::SH_IDLE)
        else $error("job taken while busy");
    ap_root_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == htnm_pkg::SH_DIVIDE |-> len >= 32'(htnm_pkg::UnitZ))
        else $error("length below unit z");

endmodule

/* rtl/height_to_normal_map.sv */
// Top level of the height to normal map block.
// Results are produced one at a time, limited by the 32-step root and the bit-serial
// byte divider; the shading unit takes no new window until its result is taken.
// Words that give no result are taken one per cycle unless input stalls.
// Input stalls once two windows wait in the queue.
// Reset clears counters, window and queue; row stores are not cleared.
module height_to_normal_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  height_sample,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  normal_red,
    output logic [7:0]  normal_green,
    output logic [7:0]  normal_blue,
    output logic        frame_end
);

    logic [10:0] width_reg, height_reg;
    logic [15:0] gain_reg;
    logic        cfg_take, restart, in_take;
    logic        job_valid, q_not_empty, q_almost_full, job_take;
    htnm_pkg::job_t job, head;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign restart   = cfg_take &&
                       (cfg_index == htnm_pkg::RegWidth || cfg_index == htnm_pkg::RegHeight);
    assign in_ready  = !q_almost_full;
    assign in_take   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd256;
            height_reg <= 11'd256;
            gain_reg   <= 16'd256;
        end
        else if (cfg_take)
        begin
            unique case (cfg_index)
                htnm_pkg::RegWidth:  width_reg  <= cfg_data[10:0];
                htnm_pkg::RegHeight: height_reg <= cfg_data[10:0];
                htnm_pkg::RegGain:   gain_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    htnm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_take       (in_take),
        .opcode        (opcode),
        .height_sample (height_sample),
        .restart       (restart),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .job_valid     (job_valid),
        .job           (job)
    );

    htnm_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (job_valid),
        .push_job    (job),
        .pop         (job_take),
        .not_empty   (q_not_empty),
        .almost_full (q_almost_full),
        .head        (head)
    );

    htnm_shade u_shade (
        .clk          (clk),
        .rst_n        (rst_n),
        .gain         (gain_reg),
        .job_valid    (q_not_empty),
        .job          (head),
        .job_take     (job_take),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .normal_red   (normal_red),
        .normal_green (normal_green),
        .normal_blue  (normal_blue),
        .frame_end    (frame_end)
    );

endmodule
